[hdl/tccw_pkg.sv]
`timescale 1ns / 1ps

package tccw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 4;

    // field widths on the stream ports
    localparam int ACTION_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int LINEAR_W  = 11;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 40;

    // colour written to every cell by the power-up sweep
    localparam logic [7:0] RESET_COLOR = 8'h07;

    // control characters
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BLANK   = 8'h00;

    // register word index on the apb port
    localparam logic REG_FILL_COLOR = 1'b0;

    // operation carried in tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

endpackage

[hdl/text_console_char_writer_core.sv]
`timescale 1ns / 1ps

// Text console writer over a ROWS x COLUMNS screen of character and colour cells.
// Commands arrive on the s_axis channel: tuser carries the operation (put
// character, clear screen, read cell), tdata the character and the cell to read.
// Every command returns exactly one transaction on m_axis with the cursor
// position after the command and, for a read, the cell contents.
// The fill colour used by clear and scroll is an APB register at address 0.
// A tab puts spaces up to the next tab stop. Any step that runs past the bottom
// row (a character, a tab space or a newline) scrolls by copying the screen
// through the two cell memories one cell a cycle. A clear sweeps every cell once.
// Only one command is worked on at a time; s_axis_tready is high while idle.
// The result sits in an output register, so the next command is taken while
// it waits; if the receiver is still stalled when that command completes,
// the engine holds until the register frees.
// After reset the engine sweeps both memories (char 0, colour 7) with
// s_axis_tready low; APB writes are taken throughout.
module text_console_char_writer_core
    import tccw_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int ROWS     = DEF_ROWS,
    parameter int TAB_STOP = DEF_TAB_STOP
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // fields: char_code[7:0], cell_col[14:8], cell_row[19:15], zero pad
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // fields: action[1:0]
    input  logic [ACTION_W-1:0] s_axis_tuser,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // fields: cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12],
    // read_char[30:23], read_color[38:31], zero pad
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELLS);
    localparam int XW         = $clog2(COLUMNS);
    localparam int YW         = $clog2(ROWS);
    localparam int PW         = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int NW         = $clog2(TAB_STOP + 1);
    localparam int SCROLL_LEN = CELLS - COLUMNS;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_BOTTOM,
        S_CLEAR,
        S_READ,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_wptr, n_wptr;
    logic              r_cpy_v, n_cpy_v;
    logic [XW-1:0]     r_cur_x, n_cur_x;
    logic [YW-1:0]     r_cur_y, n_cur_y;
    logic [PW-1:0]     r_ph, n_ph;
    logic [NW-1:0]     r_cnt, n_cnt;
    logic [CHAR_W-1:0] r_put_char, n_put_char;
    logic              r_rd_ok, n_rd_ok;
    logic [7:0]        r_res_char, n_res_char;
    logic [7:0]        r_res_color, n_res_color;
    logic [7:0]        r_fill;
    logic              r_out_valid, n_out_valid;
    logic [XW-1:0]     r_out_x, n_out_x;
    logic [YW-1:0]     r_out_y, n_out_y;
    logic [7:0]        r_out_char, n_out_char;
    logic [7:0]        r_out_color, n_out_color;

    logic              w_fin;
    logic              w_out_free;
    logic              w_char_we, w_color_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [7:0]        w_wchar, w_wcolor;
    logic [7:0]        w_q_char, w_q_color;
    logic [AW-1:0]     w_cur_addr, w_cell_addr;
    logic              w_cell_ok;
    logic              w_cfg_wr;

    t_action           w_action;
    logic [CHAR_W-1:0] w_code;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;

    // command fields
    assign w_action = t_action'(s_axis_tuser);
    assign w_code   = s_axis_tdata[7:0];
    assign w_col    = s_axis_tdata[14:8];
    assign w_row    = s_axis_tdata[19:15];

    // cell addresses
    assign w_cur_addr  = AW'(r_cur_y * COLUMNS + r_cur_x);
    assign w_cell_addr = AW'(w_row * COLUMNS + w_col);
    assign w_cell_ok   = (32'(w_col) < COLUMNS) && (32'(w_row) < ROWS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FILL_COLOR);
    assign prdata   = (paddr[2] == REG_FILL_COLOR) ? {24'd0, r_fill} : 32'd0;

    // cell memories
    tccw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_char_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wchar),
        .i_raddr (w_raddr),
        .o_rdata (w_q_char)
    );

    tccw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (w_color_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wcolor),
        .i_raddr (w_raddr),
        .o_rdata (w_q_color)
    );

    // sequencer next state and memory control
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_wptr      = r_ptr;
        n_cpy_v     = 1'b0;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_ph        = r_ph;
        n_cnt       = r_cnt;
        n_put_char  = r_put_char;
        n_rd_ok     = r_rd_ok;
        n_res_char  = r_res_char;
        n_res_color = r_res_color;
        w_fin       = 1'b0;
        w_char_we   = 1'b0;
        w_color_we  = 1'b0;
        w_waddr     = r_ptr;
        w_wchar     = CH_BLANK;
        w_wcolor    = r_fill;
        w_raddr     = AW'(r_ptr + COLUMNS);

        case (r_state)
            // power-up sweep of both memories
            S_INIT: begin
                w_char_we  = 1'b1;
                w_color_we = 1'b1;
                w_wcolor   = RESET_COLOR;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            // take a command and decode it
            S_IDLE: begin
                w_raddr = w_cell_addr;
                if (s_axis_tvalid) begin
                    n_res_char  = '0;
                    n_res_color = '0;
                    n_cnt       = '0;
                    case (w_action)
                        ACT_PUT: begin
                            case (w_code)
                                CH_NEWLINE: begin
                                    n_cur_x = '0;
                                    n_ph    = '0;
                                    if (r_cur_y == YW'(ROWS - 1)) begin
                                        n_ptr   = '0;
                                        n_state = S_SCROLL;
                                    end else begin
                                        n_cur_y = r_cur_y + 1'b1;
                                        n_state = S_DONE;
                                    end
                                end
                                CH_RETURN: begin
                                    n_cur_x = '0;
                                    n_ph    = '0;
                                    n_state = S_DONE;
                                end
                                CH_TAB: begin
                                    n_cnt      = NW'(TAB_STOP) - NW'(r_ph);
                                    n_put_char = CH_SPACE;
                                    n_state    = S_PUT;
                                end
                                default: begin
                                    n_cnt      = NW'(1);
                                    n_put_char = w_code;
                                    n_state    = S_PUT;
                                end
                            endcase
                        end
                        ACT_CLEAR: begin
                            n_cur_x = '0;
                            n_cur_y = '0;
                            n_ph    = '0;
                            n_ptr   = '0;
                            n_state = S_CLEAR;
                        end
                        ACT_READ: begin
                            n_rd_ok = w_cell_ok;
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // store one character at the cursor and advance
            S_PUT: begin
                w_char_we = 1'b1;
                w_waddr   = w_cur_addr;
                w_wchar   = r_put_char;
                n_cnt     = r_cnt - 1'b1;
                if (r_cur_x == XW'(COLUMNS - 1)) begin
                    n_cur_x = '0;
                    n_ph    = '0;
                    if (r_cur_y == YW'(ROWS - 1)) begin
                        n_ptr   = '0;
                        n_state = S_SCROLL;
                    end else begin
                        n_cur_y = r_cur_y + 1'b1;
                        w_fin   = (n_cnt == '0);
                    end
                end else begin
                    n_cur_x = r_cur_x + 1'b1;
                    n_ph    = (r_ph == PW'(TAB_STOP - 1)) ? '0 : r_ph + 1'b1;
                    w_fin   = (n_cnt == '0);
                end
            end

            // copy each cell one row up: read ahead, write in the next cycle
            S_SCROLL: begin
                w_char_we  = r_cpy_v;
                w_color_we = r_cpy_v;
                w_waddr    = r_wptr;
                w_wchar    = w_q_char;
                w_wcolor   = w_q_color;
                if (r_ptr == AW'(SCROLL_LEN)) begin
                    n_state = S_BOTTOM;
                end else begin
                    n_cpy_v = 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                end
            end

            // blank the new bottom row
            S_BOTTOM: begin
                w_char_we  = 1'b1;
                w_color_we = 1'b1;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_ptr = '0;
                    if (r_cnt == '0) begin
                        w_fin = 1'b1;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            // clear sweep with the fill colour
            S_CLEAR: begin
                w_char_we  = 1'b1;
                w_color_we = 1'b1;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_ptr = '0;
                    w_fin = 1'b1;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            // cell data arrives from the memories
            S_READ: begin
                n_res_char  = r_rd_ok ? w_q_char : '0;
                n_res_color = r_rd_ok ? w_q_color : '0;
                w_fin       = 1'b1;
            end

            S_DONE: begin
                w_fin = 1'b1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result to the output register when it is free
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_char  = r_out_char;
        n_out_color = r_out_color;
        if (w_fin) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_x     = n_cur_x;
                n_out_y     = n_cur_y;
                n_out_char  = n_res_char;
                n_out_color = n_res_color;
                n_state     = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    // state, cursor and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_cpy_v     <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_ph        <= '0;
            r_cnt       <= '0;
            r_fill      <= RESET_COLOR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cpy_v     <= n_cpy_v;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_ph        <= n_ph;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_fill <= pwdata[7:0];
            end
        end
        r_wptr      <= n_wptr;
        r_put_char  <= n_put_char;
        r_rd_ok     <= n_rd_ok;
        r_res_char  <= n_res_char;
        r_res_color <= n_res_color;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_char  <= n_out_char;
        r_out_color <= n_out_color;
    end

    // result transaction
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_color, r_out_char,
                            LINEAR_W'(r_out_y * COLUMNS + r_out_x),
                            ROW_W'(r_out_y), COL_W'(r_out_x)};

`ifndef ASSERT_OFF
    // cursor never leaves the screen
    a_cursor_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_x) < COLUMNS) && (32'(r_cur_y) < ROWS))
        else $error("cursor outside the screen");

    // the scroll copy never reads the cell it is writing
    a_scroll_sep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_cpy_v) |-> (w_waddr != w_raddr))
        else $error("scroll copy address overlap");

    // a put always has at least one character left
    a_put_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_cnt != '0))
        else $error("put with empty count");

    // no result appears before the power-up sweep has finished
    a_init_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_out_valid)
        else $error("result during power-up sweep");
`endif

endmodule

[hdl/tccw_ram.sv]
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
